@@ sv/assert_macros.svh @@
// Assertion macros shared by the key click classifier RTL.
// Standalone header; expects a clock named clk and a reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, idle while reset is asserted
`define KCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence
`define KCC_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/kcc_pkg.sv @@
// Package for the key click classifier: config register map, reset values,
// event codes and the config struct passed between modules. No dependencies.
`default_nettype none

package kcc_pkg;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_PRESS   = 2'd0,
		CFG_DOUBLE_WAIT  = 2'd1,
		CFG_DOUBLE_EN    = 2'd2,
		CFG_PRESSED_LVL  = 2'd3
	} cfg_idx_t;

	// Register reset values
	localparam logic [TICK_W-1:0] LONG_PRESS_RST  = 16'd200;
	localparam logic [TICK_W-1:0] DOUBLE_WAIT_RST = 16'd50;
	localparam logic              DOUBLE_EN_RST   = 1'b1;
	localparam logic              PRESSED_LVL_RST = 1'b0;

	// Event codes carried by each result word
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_code_t;

	// Live configuration as seen by the classifier
	typedef struct packed {
		logic [TICK_W-1:0] long_press_ticks;
		logic [TICK_W-1:0] double_wait_ticks;
		logic              double_enable;
		logic              pressed_level;
	} kcc_cfg_t;

endpackage : kcc_pkg

`default_nettype wire

@@ sv/key_click_classifier_top.sv @@
// Key click classifier: one pin sample word in, one event code word out.
// Each accepted word passes through the input register, then the result register,
// with the mode and counter update combinational between the two; throughput:
// one word per cycle while the result channel is not stalled.
// Reset: asynchronous, active low; clears mode, counter, both valid flags and
// restores the register defaults (200, 50, double on, pressed level low).
`default_nettype none

module key_click_classifier_top
	import kcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 pin_level,
	// Result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                event_code,
	// Configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_data
);

	`include "assert_macros.svh"

	kcc_cfg_t    cfg;
	logic        valid_s1;
	logic        pin_s1;
	logic        valid_s2;
	event_code_t event_s2;
	event_code_t event_next;
	logic        s2_free;
	logic        adv;
	logic        in_acc;

	assign cfg_ready = 1'b1;

	kcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the result register frees when empty or being taken
	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pin_s1 <= pin_level;
		end
	end

	kcc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.adv        (adv),
		.pin_level  (pin_s1),
		.event_next (event_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_s2 <= event_next;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = event_s2;

	`KCC_ASSERT_NEXT(a_adv_fills_result, adv, valid_s2, "word lost between stages")
	`KCC_ASSERT(a_stall_only_when_full, !in_stall || (valid_s1 && valid_s2 && out_stall),
		"input stalled with room in the pipeline")
	`KCC_ASSERT_NEXT(a_result_held, out_valid && out_stall,
		out_valid && $stable(event_code), "stalled result word changed")

endmodule : key_click_classifier_top

`default_nettype wire

@@ sv/kcc_cfg_regs.sv @@
// Configuration register bank of the key click classifier.
// Depends on kcc_pkg for the register map and reset values.
`default_nettype none

module kcc_cfg_regs
	import kcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [TICK_W-1:0]    wr_data,
	output kcc_cfg_t                  cfg
);

	logic [TICK_W-1:0] long_press_ticks_q;
	logic [TICK_W-1:0] double_wait_ticks_q;
	logic              double_enable_q;
	logic              pressed_level_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ticks_q  <= LONG_PRESS_RST;
			double_wait_ticks_q <= DOUBLE_WAIT_RST;
			double_enable_q     <= DOUBLE_EN_RST;
			pressed_level_q     <= PRESSED_LVL_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_LONG_PRESS:  long_press_ticks_q  <= wr_data;
				CFG_DOUBLE_WAIT: double_wait_ticks_q <= wr_data;
				CFG_DOUBLE_EN:   double_enable_q     <= wr_data[0];
				CFG_PRESSED_LVL: pressed_level_q     <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.long_press_ticks  = long_press_ticks_q;
	assign cfg.double_wait_ticks = double_wait_ticks_q;
	assign cfg.double_enable     = double_enable_q;
	assign cfg.pressed_level     = pressed_level_q;

endmodule : kcc_cfg_regs

`default_nettype wire

@@ sv/kcc_fsm.sv @@
// Press classifier state machine: mode, tick counter and the event decode.
// Depends on kcc_pkg and assert_macros.svh.
`default_nettype none

module kcc_fsm
	import kcc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire kcc_cfg_t  cfg,
	input  wire logic      adv,
	input  wire logic      pin_level,
	output event_code_t    event_next
);

	`include "assert_macros.svh"

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DEBOUNCE = 6'b000010,
		ST_PRESSED  = 6'b000100,
		ST_LONG     = 6'b001000,
		ST_WAIT     = 6'b010000,
		ST_SECOND   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [TICK_W-1:0] count_q, count_d;
	logic              press;
	logic              hold_hit;
	logic              wait_hit;
	logic [TICK_W-1:0] count_inc;

	assign press     = (pin_level == cfg.pressed_level);
	assign hold_hit  = (count_q >= cfg.long_press_ticks);
	assign wait_hit  = (count_q >= cfg.double_wait_ticks);
	// Counting stops at the threshold, so this never wraps
	assign count_inc = count_q + TICK_W'(1);

	// Work out the next mode, count and event for the word in the input stage
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		event_next = EV_NONE;
		unique case (state_q)
			ST_IDLE: begin
				state_d = press ? ST_DEBOUNCE : ST_IDLE;
			end
			ST_DEBOUNCE: begin
				state_d = press ? ST_PRESSED : ST_IDLE;
			end
			ST_PRESSED: begin
				if (press && hold_hit) begin
					state_d    = ST_LONG;
					event_next = EV_LONG;
					count_d    = '0;
				end else if (press) begin
					count_d = count_inc;
				end else begin
					count_d = '0;
					state_d = ST_WAIT;
				end
			end
			ST_LONG: begin
				count_d = '0;
				state_d = press ? ST_LONG : ST_IDLE;
			end
			ST_WAIT: begin
				if (!press && wait_hit) begin
					count_d    = '0;
					state_d    = ST_IDLE;
					event_next = EV_SINGLE;
				end else if (!press) begin
					count_d = count_inc;
				end else begin
					count_d = '0;
					if (cfg.double_enable) begin
						state_d = ST_SECOND;
					end else begin
						// Double detection off: report the first click now
						state_d    = ST_DEBOUNCE;
						event_next = EV_SINGLE;
					end
				end
			end
			ST_SECOND: begin
				if (press && hold_hit) begin
					// Second press held long still reports a single click
					state_d    = ST_LONG;
					event_next = EV_SINGLE;
					count_d    = '0;
				end else if (press) begin
					count_d = count_inc;
				end else begin
					count_d    = '0;
					state_d    = ST_IDLE;
					event_next = cfg.double_enable ? EV_DOUBLE : EV_SINGLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commit the update only when the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else if (adv) begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	`KCC_ASSERT_NEXT(a_hold_when_stalled, !adv,
		$stable(state_q) && $stable(count_q), "state moved without a word")
	`KCC_ASSERT_NEXT(a_long_enters_long, adv && (event_next == EV_LONG),
		state_q == ST_LONG, "long press without entering long-held")
	`KCC_ASSERT(a_count_clear,
		!((state_q == ST_IDLE) || (state_q == ST_DEBOUNCE) || (state_q == ST_LONG))
		|| (count_q == '0), "counter not clear outside counting modes")

endmodule : kcc_fsm

`default_nettype wire

@@ tb/sv/key_click_classifier_checker.sv @@
`timescale 1ns / 100ps
// Watches the key click classifier channels, predicts each event code word and
// compares it with the block's output. Depends on kcc_pkg.
`default_nettype none

module key_click_classifier_checker
	import kcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic                 pin_level,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [1:0]           event_code,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_data,
	output int                        mismatch_count,
	output int                        events_pending
);

	typedef enum logic [2:0] {
		KEY_IDLE     = 3'd0,
		KEY_DEBOUNCE = 3'd1,
		KEY_PRESSED  = 3'd2,
		KEY_LONG     = 3'd3,
		KEY_WAIT     = 3'd4,
		KEY_SECOND   = 3'd5
	} key_mode_t;

	kcc_cfg_t          live_cfg;
	key_mode_t         key_mode;
	logic [TICK_W-1:0] tick_count;
	event_code_t       expected_events[$];

	// Advance the key classifier by one scan tick and return its event
	task automatic classify_tick(input logic level, output event_code_t ev);
		logic pressed;
		pressed = (level == live_cfg.pressed_level);
		ev = EV_NONE;
		case (key_mode)
			KEY_IDLE: key_mode = pressed ? KEY_DEBOUNCE : KEY_IDLE;
			KEY_DEBOUNCE: key_mode = pressed ? KEY_PRESSED : KEY_IDLE;
			KEY_PRESSED: begin
				if (pressed && tick_count >= live_cfg.long_press_ticks) begin
					key_mode = KEY_LONG;
					ev = EV_LONG;
					tick_count = '0;
				end else if (pressed) begin
					tick_count = tick_count + 1'b1;
				end else begin
					tick_count = '0;
					key_mode = KEY_WAIT;
				end
			end
			KEY_LONG: begin
				tick_count = '0;
				key_mode = pressed ? KEY_LONG : KEY_IDLE;
			end
			KEY_WAIT: begin
				if (!pressed && tick_count >= live_cfg.double_wait_ticks) begin
					tick_count = '0;
					key_mode = KEY_IDLE;
					ev = EV_SINGLE;
				end else if (!pressed) begin
					tick_count = tick_count + 1'b1;
				end else begin
					tick_count = '0;
					if (live_cfg.double_enable) begin
						key_mode = KEY_SECOND;
					end else begin
						// double detection off: the new press is debounced afresh
						key_mode = KEY_DEBOUNCE;
						ev = EV_SINGLE;
					end
				end
			end
			KEY_SECOND: begin
				// a second press held long still reports only a single click
				if (pressed && tick_count >= live_cfg.long_press_ticks) begin
					key_mode = KEY_LONG;
					ev = EV_SINGLE;
					tick_count = '0;
				end else if (pressed) begin
					tick_count = tick_count + 1'b1;
				end else begin
					tick_count = '0;
					key_mode = KEY_IDLE;
					ev = live_cfg.double_enable ? EV_DOUBLE : EV_SINGLE;
				end
			end
			default: key_mode = KEY_IDLE;
		endcase
	endtask

	// Track registers, predict accepted words and check result words
	always @(posedge clk or negedge arst_n) begin
		event_code_t ev;
		event_code_t want;
		if (!arst_n) begin
			live_cfg.long_press_ticks  = LONG_PRESS_RST;
			live_cfg.double_wait_ticks = DOUBLE_WAIT_RST;
			live_cfg.double_enable     = DOUBLE_EN_RST;
			live_cfg.pressed_level     = PRESSED_LVL_RST;
			key_mode = KEY_IDLE;
			tick_count = '0;
			expected_events.delete();
			mismatch_count <= 0;
			events_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LONG_PRESS:  live_cfg.long_press_ticks  = cfg_data;
					CFG_DOUBLE_WAIT: live_cfg.double_wait_ticks = cfg_data;
					CFG_DOUBLE_EN:   live_cfg.double_enable     = cfg_data[0];
					CFG_PRESSED_LVL: live_cfg.pressed_level     = cfg_data[0];
					default: ;
				endcase
			end
			// compare the outgoing word before queueing the incoming one
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("event_code: unexpected word, expected none, actual %0d",
						event_code);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_events.pop_front();
					if (event_code !== want) begin
						$error("event_code: expected %0d, actual %0d", want, event_code);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				classify_tick(pin_level, ev);
				expected_events.push_back(ev);
			end
			events_pending <= expected_events.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/key_click_classifier_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the key click classifier: drives pin sample words and
// register writes, and takes the verdict from key_click_classifier_checker.
`default_nettype none

module key_click_classifier_top_tb;
	import kcc_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int RUN_CAP = 40;
	localparam int PHASE_ITEMS = 160;
	localparam int PHASES = 8;

	// Short presses, a bounce, an expired wait, a double click and a long hold
	localparam bit DIRECTED [24] = '{
		1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 pin_level = 1'b0;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LONG_PRESS;
	logic [TICK_W-1:0]    cfg_data = '0;
	wire logic            in_stall;
	wire logic            out_valid;
	wire logic            cfg_ready;
	wire logic [1:0]      event_code;
	int                   mismatch_count;
	int                   events_pending;

	int                   cycle_count = 0;
	int                   stall_pct = 0;
	int                   gap_max = 0;
	int                   burst_left = 0;
	int                   words_sent = 0;
	logic [TICK_W-1:0]    cur_long;
	logic [TICK_W-1:0]    cur_wait;
	logic                 cur_level;

	key_click_classifier_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pin_level(pin_level),
		.out_valid(out_valid), .out_stall(out_stall), .event_code(event_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	key_click_classifier_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pin_level(pin_level),
		.out_valid(out_valid), .out_stall(out_stall), .event_code(event_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .events_pending(events_pending)
	);

	always #1 clk = ~clk;

	// Stall the result channel at the rate set for the phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("key_click_classifier_top test failed");
			$finish;
		end
	end

	// Present one register write and hold it until taken
	task automatic write_reg(input cfg_idx_t idx, input logic [TICK_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain outstanding words, then rewrite all four registers
	task automatic configure(input logic [TICK_W-1:0] long_ticks,
			input logic [TICK_W-1:0] wait_ticks, input logic dbl_en, input logic level);
		logic [TICK_W-1:0] pad_en;
		logic [TICK_W-1:0] pad_lvl;
		pad_en = TICK_W'($urandom) & 16'hFFFE;
		pad_lvl = TICK_W'($urandom) & 16'hFFFE;
		// let the pending count catch up with the last accepted word first
		repeat (4) @(posedge clk);
		while (events_pending != 0) @(posedge clk);
		write_reg(CFG_LONG_PRESS, long_ticks);
		write_reg(CFG_DOUBLE_WAIT, wait_ticks);
		write_reg(CFG_DOUBLE_EN, pad_en | TICK_W'(dbl_en));
		write_reg(CFG_PRESSED_LVL, pad_lvl | TICK_W'(level));
		cfg_valid <= 1'b0;
		cur_long = long_ticks;
		cur_wait = wait_ticks;
		cur_level = level;
	endtask

	// Send one pin word, then idle between bursts
	task automatic send_word(input logic level);
		int gap;
		in_valid <= 1'b1;
		pin_level <= level;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic send_run(input logic pressed, input int count);
		repeat (count) send_word(pressed ? cur_level : ~cur_level);
	endtask

	// Press and release runs around the thresholds, with some noise
	task automatic random_phase(input int target);
		int hold_cap;
		int rel_cap;
		hold_cap = (int'(cur_long) + 4 > RUN_CAP) ? RUN_CAP : int'(cur_long) + 4;
		rel_cap = (int'(cur_wait) + 4 > RUN_CAP) ? RUN_CAP : int'(cur_wait) + 4;
		while (words_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(0, 1)));
			end else begin
				if ($urandom_range(0, 3) == 0)
					send_run(1'b1, $urandom_range(1, 2));
				else
					send_run(1'b1, $urandom_range(1, hold_cap));
				send_run(1'b0, $urandom_range(1, rel_cap));
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [TICK_W-1:0] phase_long [PHASES];
		logic [TICK_W-1:0] phase_wait [PHASES];
		logic              phase_dbl  [PHASES];
		logic              phase_lvl  [PHASES];
		int                phase_gap  [PHASES];
		int                phase_stall [PHASES];
		int                target;
		phase_long  = '{16'd0, 16'd3, 16'd7, 16'hFFFF, 16'd5, 16'd1, 16'd0, 16'd0};
		phase_wait  = '{16'd0, 16'd5, 16'd4, 16'hFFFF, 16'd0, 16'd10, 16'd0, 16'd0};
		phase_dbl   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		phase_lvl   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
		phase_gap   = '{0, 3, 1, 6, 0, 4, 2, 8};
		phase_stall = '{0, 30, 50, 10, 0, 70, 20, 40};
		// randomise the thresholds of the last two phases
		for (int p = PHASES - 2; p < PHASES; p++) begin
			phase_long[p] = TICK_W'($urandom_range(0, 12));
			phase_wait[p] = TICK_W'($urandom_range(0, 12));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with tiny thresholds, key pressed at level low
		configure(16'd2, 16'd2, 1'b1, 1'b0);
		foreach (DIRECTED[i]) send_word(DIRECTED[i]);
		in_valid <= 1'b0;

		target = words_sent;
		for (int p = 0; p < PHASES; p++) begin
			configure(phase_long[p], phase_wait[p], phase_dbl[p], phase_lvl[p]);
			gap_max = phase_gap[p];
			stall_pct = phase_stall[p];
			target += PHASE_ITEMS;
			random_phase(target);
		end

		// drain every outstanding word; a lost word hangs here until the limit
		repeat (4) @(posedge clk);
		while (events_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("key_click_classifier_top test passed");
		else
			$display("key_click_classifier_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
